// File: rtl/jka_pkg.sv
// Package: constants, codes, command and status types for the key auto-repeat block
package jka_pkg;

    localparam int NUM_KEYS = 64;
    localparam int SLOTS = 64;
    localparam int KEY_W = 6;
    localparam int CNT_W = KEY_W + 1;
    localparam int TIME_W = 32;
    localparam int LFSR_W = 16;
    localparam int JIT_INIT_W = 7;
    localparam int JIT_REP_W = 6;
    localparam int DELAY_INIT = 128;
    localparam int DELAY_REPEAT = 64;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] ACT_PRESS = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_PASS_PRESS = 2'd2;
    localparam logic [1:0] ACT_PASS_RELEASE = 2'd3;

    typedef struct packed {
        logic load;
        logic key_exec;
        logic scan_exec;
        logic scan_next;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic is_scan;
        logic due;
        logic pend_valid;
        logic out_free;
        logic scan_last;
    } sts_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

// File: rtl/jka_if.sv
// Interfaces: request, result and configuration write channels
interface jka_req_if import jka_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [KEY_W-1:0]  key_index;
    logic              key_pressed;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, req_type, key_index, key_pressed, now_ms, input ready);
    modport sink (input valid, req_type, key_index, key_pressed, now_ms, output ready);
endinterface

interface jka_res_if import jka_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] out_key;
    logic [1:0]       action;
    logic             last_of_run;

    modport source (output valid, out_key, action, last_of_run, input ready);
    modport sink (input valid, out_key, action, last_of_run, output ready);
endinterface

interface jka_cfg_if;
    logic valid;
    logic ready;
    logic config_mode;

    modport source (output valid, config_mode, input ready);
    modport sink (input valid, config_mode, output ready);
endinterface

// File: rtl/jka_ctrl.sv
// Controller: sequences key events, scan sweeps and result flushing
module jka_ctrl
    import jka_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEY_RD = 3'd1;
    localparam logic [2:0] S_KEY_EV = 3'd2;
    localparam logic [2:0] S_SCAN_RD = 3'd3;
    localparam logic [2:0] S_SCAN_EV = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       scan_stall;

    assign in_ready = (state_reg == S_IDLE);
    assign scan_stall = sts.due && sts.pend_valid && !sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_KEY_RD;
                end
            end
            S_KEY_RD:
            begin
                state_next = sts.is_scan ? S_SCAN_EV : S_KEY_EV;
            end
            S_KEY_EV:
            begin
                cmd.key_exec = 1'b1;
                state_next = S_FLUSH;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (!scan_stall)
                begin
                    cmd.scan_exec = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.scan_next = 1'b1;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !sts.pend_valid)
        else $error("pending result left over at idle");

    a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_EV) && scan_stall |=> state_reg == S_SCAN_EV)
        else $error("scan advanced while result path blocked");

    a_key_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_KEY_EV |=> state_reg == S_FLUSH)
        else $error("key event did not flush");

endmodule

// File: rtl/jka_dp.sv
// Datapath: per-key flags, trigger time memory, random source and result registers
module jka_dp
    import jka_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              in_req_type,
    input  logic [KEY_W-1:0]  in_key_index,
    input  logic              in_key_pressed,
    input  logic [TIME_W-1:0] in_now_ms,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KEY_W-1:0]  out_key,
    output logic [1:0]        out_action,
    output logic              out_last
);

    logic [TIME_W-1:0] trig_mem [SLOTS];
    logic [TIME_W-1:0] trig_rd_reg;
    logic              trig_rd_vld_reg;
    logic [SLOTS-1:0]  trig_vld_reg;
    logic [SLOTS-1:0]  trig_vld_next;

    logic [SLOTS-1:0]  en_reg, en_next;
    logic [SLOTS-1:0]  held_reg, held_next;
    logic [SLOTS-1:0]  hrel_reg, hrel_next;
    logic [SLOTS-1:0]  auto_reg, auto_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic              cfg_mode_reg, cfg_mode_next;
    logic              scan_reg, scan_next;
    logic [KEY_W-1:0]  cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;

    logic [KEY_W-1:0]  key_reg;
    logic              press_reg;
    logic [TIME_W-1:0] now_reg;
    logic [KEY_W-1:0]  pend_key_reg, pend_key_next;
    logic [1:0]        pend_act_reg, pend_act_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [1:0]        out_act_reg, out_act_next;
    logic              out_last_reg, out_last_next;

    logic [KEY_W-1:0]  addr;
    logic [TIME_W-1:0] trig_cur;
    logic [LFSR_W-1:0] lfsr_adv;
    logic              in_range;
    logic              due;
    logic              out_free;
    logic              trig_we;
    logic [TIME_W-1:0] trig_wdata;

    assign addr = scan_reg ? cnt_reg : key_reg;
    assign trig_cur = trig_rd_vld_reg ? trig_rd_reg : '0;
    assign lfsr_adv = lfsr_step(lfsr_reg);
    assign in_range = ({1'b0, key_reg} < CNT_W'(NUM_KEYS));
    assign due = en_reg[addr] && held_reg[addr] && (trig_cur <= now_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign sts.is_scan = scan_reg;
    assign sts.due = due;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free = out_free;
    assign sts.scan_last = (cnt_reg == KEY_W'(NUM_KEYS - 1));

    assign out_valid = out_valid_reg;
    assign out_key = out_key_reg;
    assign out_action = out_act_reg;
    assign out_last = out_last_reg;

    always_comb
    begin
        en_next = en_reg;
        held_next = held_reg;
        hrel_next = hrel_reg;
        auto_next = auto_reg;
        lfsr_next = lfsr_reg;
        cfg_mode_next = cfg_we ? cfg_data : cfg_mode_reg;
        scan_next = scan_reg;
        cnt_next = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next = pend_key_reg;
        pend_act_next = pend_act_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_key_next = out_key_reg;
        out_act_next = out_act_reg;
        out_last_next = out_last_reg;
        trig_vld_next = trig_vld_reg;
        trig_we = 1'b0;
        trig_wdata = '0;

        if (cmd.load)
        begin
            scan_next = in_req_type;
            cnt_next = '0;
        end

        if (cmd.key_exec)
        begin
            if (cfg_mode_reg)
            begin
                if (in_range && !press_reg)
                begin
                    en_next[addr] = !en_reg[addr];
                end
            end
            else if (!in_range || !en_reg[addr])
            begin
                pend_valid_next = 1'b1;
                pend_key_next = key_reg;
                pend_act_next = press_reg ? ACT_PASS_PRESS : ACT_PASS_RELEASE;
            end
            else if (press_reg)
            begin
                held_next[addr] = 1'b1;
                hrel_next[addr] = 1'b0;
                lfsr_next = lfsr_adv;
                trig_we = 1'b1;
                trig_wdata = now_reg + TIME_W'(DELAY_INIT)
                           + TIME_W'(lfsr_adv[JIT_INIT_W-1:0]);
                pend_valid_next = 1'b1;
                pend_key_next = key_reg;
                pend_act_next = ACT_PRESS;
            end
            else
            begin
                held_next[addr] = 1'b0;
                if (((now_reg < trig_cur) && !hrel_reg[addr]) || auto_reg[addr])
                begin
                    auto_next[addr] = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_key_next = key_reg;
                    pend_act_next = ACT_RELEASE;
                end
            end
        end

        if (cmd.scan_exec && due)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_key_next = pend_key_reg;
                out_act_next = pend_act_reg;
                out_last_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_key_next = cnt_reg;
            if (!hrel_reg[addr])
            begin
                hrel_next[addr] = 1'b1;
                auto_next[addr] = 1'b0;
                pend_act_next = ACT_RELEASE;
            end
            else if (!auto_reg[addr])
            begin
                auto_next[addr] = 1'b1;
                pend_act_next = ACT_PRESS;
            end
            else
            begin
                auto_next[addr] = 1'b0;
                pend_act_next = ACT_RELEASE;
            end
            lfsr_next = lfsr_adv;
            trig_we = 1'b1;
            trig_wdata = now_reg + TIME_W'(DELAY_REPEAT)
                       + TIME_W'(lfsr_adv[JIT_REP_W-1:0]);
        end

        if (cmd.scan_next)
        begin
            cnt_next = cnt_reg + KEY_W'(1);
        end

        if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
            out_valid_next = 1'b1;
            out_key_next = pend_key_reg;
            out_act_next = pend_act_reg;
            out_last_next = 1'b1;
        end

        if (trig_we)
        begin
            trig_vld_next[addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= '0;
            held_reg <= '0;
            hrel_reg <= '0;
            auto_reg <= '0;
            lfsr_reg <= LFSR_SEED;
            cfg_mode_reg <= 1'b0;
            scan_reg <= 1'b0;
            cnt_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            trig_vld_reg <= '0;
            trig_rd_vld_reg <= 1'b0;
        end
        else
        begin
            en_reg <= en_next;
            held_reg <= held_next;
            hrel_reg <= hrel_next;
            auto_reg <= auto_next;
            lfsr_reg <= lfsr_next;
            cfg_mode_reg <= cfg_mode_next;
            scan_reg <= scan_next;
            cnt_reg <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
            trig_vld_reg <= trig_vld_next;
            trig_rd_vld_reg <= trig_vld_reg[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_key_index;
            press_reg <= in_key_pressed;
            now_reg <= in_now_ms;
        end
        pend_key_reg <= pend_key_next;
        pend_act_reg <= pend_act_next;
        out_key_reg <= out_key_next;
        out_act_reg <= out_act_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (trig_we)
        begin
            trig_mem[addr] <= trig_wdata;
        end
        trig_rd_reg <= trig_mem[addr];
    end

endmodule

// File: rtl/jittered_key_autorepeat.sv
// Top level: key auto-repeat engine with jittered repeat timing
//
// Requests arrive on req: a key event (req_type 0, key_index, key_pressed) or
// a scan tick (req_type 1), each with the current millisecond time now_ms.
// Results leave on res as (out_key, action, last_of_run); last_of_run marks
// the final result of a request. A request may give no result at all.
// cfg carries the single config_mode bit; write it only while idle.
// One request is worked at a time; req.ready is high only when idle.
// Key event: the trigger time is read (S_KEY_RD), the event is evaluated
// (S_KEY_EV) and the result is flushed to the output register (S_FLUSH).
// Scan tick: each key slot gets a registered trigger time memory read
// (S_KEY_RD for slot 0, S_SCAN_RD after) and an evaluation (S_SCAN_EV); after
// the last slot the held result is flushed and the block returns to idle.
// One result is held back so that the last of a run can be marked; results
// then pass through a single output register.
// A stalled receiver holds the output register and, once a second result is
// waiting, halts the sweep at the next due key slot until the register drains.
// Reset clears all per-key state and trigger time valid bits at once and reseeds the
// random source; the block accepts requests as soon as reset is released.
module jittered_key_autorepeat
    import jka_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    jka_req_if.sink  req,
    jka_res_if.source res,
    jka_cfg_if.sink  cfg
);

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    jka_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    jka_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_req_type    (req.req_type),
        .in_key_index   (req.key_index),
        .in_key_pressed (req.key_pressed),
        .in_now_ms      (req.now_ms),
        .cfg_we         (cfg.valid),
        .cfg_data       (cfg.config_mode),
        .out_valid      (res.valid),
        .out_ready      (res.ready),
        .out_key        (res.out_key),
        .out_action     (res.action),
        .out_last       (res.last_of_run)
    );

endmodule

// File: bench/tb_top.sv
// Testbench for the key auto-repeat block: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import jka_pkg::*;

    localparam int IDLE_PCT = 28;
    localparam int SETTLE_CYCLES = 2 * NUM_KEYS + 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int BURST_KEYS = 16;

    typedef struct packed {
        logic              req_type;
        logic [KEY_W-1:0]  key_index;
        logic              key_pressed;
        logic [TIME_W-1:0] now_ms;
    } key_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [1:0]       action;
        logic             last_of_run;
    } key_act_t;

    class action_board;
        bit                cfg_mode;
        bit                rep_en[NUM_KEYS];
        bit                held[NUM_KEYS];
        bit                hold_done[NUM_KEYS];
        bit                auto_on[NUM_KEYS];
        logic [TIME_W-1:0] due_at[NUM_KEYS];
        logic [LFSR_W-1:0] jitter_state;
        key_act_t          host_actions[$];
        int                faults;

        function new();
            cfg_mode = 1'b0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                rep_en[k] = 1'b0;
                held[k] = 1'b0;
                hold_done[k] = 1'b0;
                auto_on[k] = 1'b0;
                due_at[k] = '0;
            end
            jitter_state = LFSR_SEED;
            faults = 0;
        endfunction

        function logic [TIME_W-1:0] next_jitter();
            logic [LFSR_W-1:0] s;
            s = jitter_state >> 1;
            if (jitter_state[0])
            begin
                s = s ^ LFSR_TAPS;
            end
            jitter_state = s;
            return TIME_W'(s);
        endfunction

        function void note_request(key_req_t r);
            key_act_t run[$];
            int       k;
            k = int'(r.key_index);
            if (!r.req_type)
            begin
                if (cfg_mode)
                begin
                    if (!r.key_pressed)
                    begin
                        rep_en[k] = !rep_en[k];
                    end
                end
                else if (!rep_en[k])
                begin
                    run.push_back(key_act_t'{r.key_index,
                        r.key_pressed ? ACT_PASS_PRESS : ACT_PASS_RELEASE, 1'b0});
                end
                else if (r.key_pressed)
                begin
                    held[k] = 1'b1;
                    hold_done[k] = 1'b0;
                    due_at[k] = r.now_ms + TIME_W'(DELAY_INIT) + (next_jitter() & 32'h7F);
                    run.push_back(key_act_t'{r.key_index, ACT_PRESS, 1'b0});
                end
                else
                begin
                    held[k] = 1'b0;
                    if ((r.now_ms < due_at[k] && !hold_done[k]) || auto_on[k])
                    begin
                        auto_on[k] = 1'b0;
                        run.push_back(key_act_t'{r.key_index, ACT_RELEASE, 1'b0});
                    end
                end
            end
            else
            begin
                for (int j = 0; j < NUM_KEYS; j++)
                begin
                    if (rep_en[j] && held[j] && due_at[j] <= r.now_ms)
                    begin
                        if (!hold_done[j])
                        begin
                            hold_done[j] = 1'b1;
                            auto_on[j] = 1'b0;
                            run.push_back(key_act_t'{KEY_W'(j), ACT_RELEASE, 1'b0});
                        end
                        else if (!auto_on[j])
                        begin
                            auto_on[j] = 1'b1;
                            run.push_back(key_act_t'{KEY_W'(j), ACT_PRESS, 1'b0});
                        end
                        else
                        begin
                            auto_on[j] = 1'b0;
                            run.push_back(key_act_t'{KEY_W'(j), ACT_RELEASE, 1'b0});
                        end
                        due_at[j] = r.now_ms + TIME_W'(DELAY_REPEAT)
                            + (next_jitter() & 32'h3F);
                    end
                end
            end
            if (run.size() > 0)
            begin
                run[run.size() - 1].last_of_run = 1'b1;
            end
            foreach (run[i])
            begin
                host_actions.push_back(run[i]);
            end
        endfunction

        function void check_action(key_act_t got);
            key_act_t want;
            if (host_actions.size() == 0)
            begin
                $error("unexpected result: out_key %0d action %0d last_of_run %0d",
                    got.out_key, got.action, got.last_of_run);
                faults++;
                return;
            end
            want = host_actions.pop_front();
            if (got.out_key !== want.out_key)
            begin
                $error("out_key: expected %0d, actual %0d", want.out_key, got.out_key);
                faults++;
            end
            if (got.action !== want.action)
            begin
                $error("action: expected %0d, actual %0d", want.action, got.action);
                faults++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0d, actual %0d",
                    want.last_of_run, got.last_of_run);
                faults++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    bit                steady;
    bit                hold_request;
    int                hold_left;
    int                quiet_cycles;
    logic [TIME_W-1:0] t_ms;
    action_board       sb;

    jka_req_if req_ch ();
    jka_res_if res_ch ();
    jka_cfg_if cfg_ch ();

    jittered_key_autorepeat DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        res_ch.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                res_ch.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid && res_ch.ready)
        begin
            sb.check_action(key_act_t'{res_ch.out_key, res_ch.action, res_ch.last_of_run});
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("jittered_key_autorepeat: mismatch");
                $finish;
            end
        end
    end

    task automatic send_request(input logic is_tick, input int key, input logic down,
                                input logic [TIME_W-1:0] now);
        key_req_t item;
        item = key_req_t'{is_tick, KEY_W'(key), down, now};
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.req_type = item.req_type;
        req_ch.key_index = item.key_index;
        req_ch.key_pressed = item.key_pressed;
        req_ch.now_ms = item.now_ms;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(item);
        @(negedge clk);
    endtask

    task automatic settle();
        req_ch.valid = 1'b0;
        while (sb.host_actions.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        settle();
        cfg_ch.valid = 1'b1;
        cfg_ch.config_mode = mode;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.cfg_mode = mode;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic random_requests(input int count);
        int pick;
        int key;
        for (int i = 0; i < count; i++)
        begin
            t_ms = t_ms + $urandom_range(0, 150);
            pick = $urandom_range(0, 99);
            key = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) * 9 : $urandom_range(0, 63);
            if (pick < 8)
            begin
                send_request(1'($urandom_range(0, 1)), key, 1'($urandom_range(0, 1)),
                    $urandom());
            end
            else if (pick < 40)
            begin
                send_request(1'b1, $urandom_range(0, 63), 1'($urandom_range(0, 1)), t_ms);
            end
            else
            begin
                send_request(1'b0, key, pick < 70, t_ms);
            end
        end
    endtask

    initial
    begin
        sb = new();
        steady = 1'b0;
        hold_request = 1'b0;
        t_ms = '0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.key_index = '0;
        req_ch.key_pressed = 1'b0;
        req_ch.now_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.config_mode = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        write_mode(1'b0);
        send_request(1'b0, 0, 1'b1, 32'd0);
        send_request(1'b0, 63, 1'b0, 32'd1);
        send_request(1'b1, 0, 1'b0, 32'hFFFF_FFFF);

        write_mode(1'b1);
        send_request(1'b0, 0, 1'b1, 32'd2);
        send_request(1'b0, 0, 1'b0, 32'd3);
        send_request(1'b0, 63, 1'b0, 32'd4);
        send_request(1'b0, 33, 1'b0, 32'd5);
        send_request(1'b1, 0, 1'b0, 32'd6);

        write_mode(1'b0);
        send_request(1'b0, 0, 1'b1, 32'd1000);
        send_request(1'b0, 0, 1'b0, 32'd1001);
        send_request(1'b0, 63, 1'b1, 32'd2000);
        send_request(1'b1, 0, 1'b0, 32'd2000);
        send_request(1'b1, 0, 1'b0, 32'd2300);
        send_request(1'b1, 0, 1'b0, 32'd2500);
        send_request(1'b1, 0, 1'b0, 32'd2700);
        send_request(1'b1, 0, 1'b0, 32'd2900);
        send_request(1'b0, 63, 1'b0, 32'd2950);
        send_request(1'b0, 33, 1'b1, 32'd3000);
        send_request(1'b1, 0, 1'b0, 32'd3400);
        send_request(1'b0, 33, 1'b0, 32'd3401);
        send_request(1'b0, 5, 1'b0, 32'd3402);
        send_request(1'b0, 0, 1'b1, 32'hFFFF_FFC0);
        send_request(1'b1, 0, 1'b0, 32'hFFFF_FFC1);
        send_request(1'b0, 0, 1'b0, 32'hFFFF_FFC2);

        // enable the first keys, hold them all, then let one tick fire the lot
        write_mode(1'b1);
        for (int k = 0; k < BURST_KEYS; k++)
        begin
            if (!sb.rep_en[k])
            begin
                send_request(1'b0, k, 1'b0, t_ms);
            end
        end
        write_mode(1'b0);
        t_ms = 32'd5000;
        for (int k = 0; k < BURST_KEYS; k++)
        begin
            send_request(1'b0, k, 1'b1, t_ms + k);
        end
        hold_request = 1'b1;
        send_request(1'b1, 0, 1'b0, t_ms + 500);
        t_ms = t_ms + 600;
        random_requests(16);

        write_mode(1'b1);
        random_requests(8);
        write_mode(1'b0);
        steady = 1'b1;
        random_requests(20);
        steady = 1'b0;
        write_mode(1'b1);
        random_requests(4);
        write_mode(1'b0);
        random_requests(6);
        settle();

        if (sb.faults == 0)
        begin
            $display("jittered_key_autorepeat: match");
        end
        else
        begin
            $display("jittered_key_autorepeat: mismatch");
        end
        $finish;
    end

endmodule
